[hdl/mae_pkg.sv]
// Shared types and constants for the matrix add/multiply engine.
`timescale 1ns / 1ps
package mae_pkg;

  localparam int IDX_W  = 3;   // row, column and inner-index width
  localparam int DIM_W  = 4;   // configuration register width
  localparam int DATA_W = 32;
  localparam int CELL_ROWS = 1 << IDX_W;

  localparam logic [2:0] REG_ROWS_A    = 3'd0;
  localparam logic [2:0] REG_COLS_A    = 3'd1;
  localparam logic [2:0] REG_COLS_B    = 3'd2;
  localparam logic [2:0] REG_OPERATION = 3'd3;
  localparam logic [2:0] REG_ELEM_KIND = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] im;
    logic [DATA_W-1:0] re;
  } elem_t;

  // token that walks the cell row: one element of A plus its inner index
  typedef struct packed {
    logic             v;
    logic             first;
    logic [IDX_W-1:0] h;
    elem_t            a;
  } tok_t;

  typedef struct packed {
    logic             mul;
    logic             cplx;
    logic [IDX_W-1:0] brd_row;
    logic             b_we;
    logic [IDX_W-1:0] b_row;
    logic [IDX_W-1:0] b_col;
    logic             snap;
    logic             shift;
  } cell_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                  input logic [DIM_W-1:0] dmax);
    logic [DIM_W-1:0] v;
    begin
      v = d;
      if (d == '0) v = DIM_W'(1);
      else if (d > dmax) v = dmax;
      return v;
    end
  endfunction

endpackage

[hdl/mae_if.sv]
// Valid/ready channel interfaces for the element input and result output.
`timescale 1ns / 1ps
interface mae_in_if;
  logic               valid;
  logic               ready;
  logic               to_second;
  logic signed [31:0] elem_re;
  logic signed [31:0] elem_im;
  modport source (output valid, output to_second, output elem_re, output elem_im,
                  input ready);
  modport sink (input valid, input to_second, input elem_re, input elem_im,
                output ready);
endinterface

interface mae_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_row;
  logic [2:0]         out_col;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic               last;
  modport source (output valid, output out_row, output out_col, output res_re,
                  output res_im, output last, input ready);
  modport sink (input valid, input out_row, input out_col, input res_re,
                input res_im, input last, output ready);
endinterface

[hdl/mae_cell.sv]
// One column cell: holds a column of B, multiplies/adds passing A tokens, accumulates.
`timescale 1ns / 1ps
module mae_cell #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mae_pkg::cell_ctl_t   ctl,
  input  mae_pkg::elem_t       b_wdata,
  input  mae_pkg::tok_t        tok_in,
  output mae_pkg::tok_t        tok_out,
  input  mae_pkg::elem_t       res_in,
  output mae_pkg::elem_t       res_out
);
  import mae_pkg::*;

  localparam logic [IDX_W-1:0] MY_COL = IDX_W'(IDX);

  elem_t            bmem_r [0:CELL_ROWS-1];
  elem_t            b_rd;
  tok_t             tok_r;
  logic             s1_v_r, s1_first_r;
  logic [DATA_W-1:0] re_a_r, re_b_r, im_a_r, im_b_r;
  logic [DATA_W-1:0] re_a_nxt, re_b_nxt, im_a_nxt, im_b_nxt;
  logic [DATA_W-1:0] term_re, term_im;
  elem_t            acc_r, res_r;

  always_ff @(posedge clk) begin
    if (ctl.b_we && ctl.b_col == MY_COL) bmem_r[ctl.b_row] <= b_wdata;
  end

  assign b_rd = bmem_r[ctl.mul ? tok_in.h : ctl.brd_row];

  // add mode folds into the same form: re = a - (-b), im = a + b
  always_comb begin
    if (ctl.mul) begin
      re_a_nxt = tok_in.a.re * b_rd.re;
      re_b_nxt = ctl.cplx ? tok_in.a.im * b_rd.im : '0;
      im_a_nxt = tok_in.a.re * b_rd.im;
      im_b_nxt = tok_in.a.im * b_rd.re;
    end else begin
      re_a_nxt = tok_in.a.re;
      re_b_nxt = '0 - b_rd.re;
      im_a_nxt = tok_in.a.im;
      im_b_nxt = b_rd.im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.v <= 1'b0;
      s1_v_r  <= 1'b0;
    end else begin
      tok_r.v <= tok_in.v;
      s1_v_r  <= tok_in.v && (ctl.mul || tok_in.h == MY_COL);
    end
    tok_r.first <= tok_in.first;
    tok_r.h     <= tok_in.h;
    tok_r.a     <= tok_in.a;
    s1_first_r  <= tok_in.first || !ctl.mul;
    re_a_r <= re_a_nxt;
    re_b_r <= re_b_nxt;
    im_a_r <= im_a_nxt;
    im_b_r <= im_b_nxt;
  end

  assign term_re = re_a_r - re_b_r;
  assign term_im = im_a_r + im_b_r;

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      acc_r.re <= s1_first_r ? term_re : acc_r.re + term_re;
      acc_r.im <= s1_first_r ? term_im : acc_r.im + term_im;
    end
    if (ctl.snap) res_r <= acc_r;
    else if (ctl.shift) res_r <= res_in;
  end

  assign tok_out = tok_r;
  assign res_out = res_r;

endmodule

[hdl/matrix_add_multiply_engine_top.sv]
// Top level: load stores, B distribution sweep, row sequencer and the cell row.
//
//  channel | dir | handshake      | payload
//  in_ch   | in  | valid/ready    | to_second, elem_re, elem_im
//  out_ch  | out | valid/ready    | out_row, out_col, res_re, res_im, last
//  cfg     | in  | cfg_we         | cfg_idx, cfg_data
//
// Loading accepts one element per cycle in the load state. The request completing B starts
// a sweep that moves B from its store into the cells, then each result row issues its cols_a
// A elements into the cell row, drains through it and emits one column per cycle unless
// the output stalls. Input is held off from completion until the last result is taken.
// Synchronous active-low reset; stores are not cleared. Output stalls freeze the row.
`timescale 1ns / 1ps
module matrix_add_multiply_engine_top #(
  parameter int MAX_DIM = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  mae_in_if.sink      in_ch,
  mae_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [3:0]  cfg_data
);
  import mae_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DRAIN_LEN = MAX_DIM + 3;
  localparam int DRW   = $clog2(DRAIN_LEN + 1);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_ROW   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [DIM_W-1:0] rows_a_r, cols_a_r, cols_b_r;
  logic             op_r, kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(1);
      cols_a_r <= DIM_W'(1);
      cols_b_r <= DIM_W'(1);
      op_r     <= 1'b0;
      kind_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROWS_A:    rows_a_r <= cfg_data;
        REG_COLS_A:    cols_a_r <= cfg_data;
        REG_COLS_B:    cols_b_r <= cfg_data;
        REG_OPERATION: op_r     <= cfg_data[0];
        REG_ELEM_KIND: kind_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] dmax, r_d, ca_d, cb_d, ncols, nrows_b;
  logic [7:0]       prod_a, prod_b;
  logic [CW-1:0]    size_a, size_b;

  assign dmax    = DIM_W'(MAX_DIM);
  assign r_d     = clamp_dim(rows_a_r, dmax);
  assign ca_d    = clamp_dim(cols_a_r, dmax);
  assign cb_d    = clamp_dim(cols_b_r, dmax);
  assign ncols   = op_r ? cb_d : ca_d;
  assign nrows_b = op_r ? ca_d : r_d;
  assign prod_a  = {4'b0, r_d} * {4'b0, ca_d};
  assign prod_b  = {4'b0, nrows_b} * {4'b0, ncols};
  assign size_a  = prod_a[CW-1:0];
  assign size_b  = prod_b[CW-1:0];

  // load side
  logic          in_acc, a_full, a_we, b_we, b_done;
  logic [CW-1:0] cnt_a_r, cnt_b_r;
  elem_t         in_elem;

  assign in_ch.ready = (state_r == S_LOAD);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign in_elem = '{im: in_ch.elem_im, re: in_ch.elem_re};
  assign a_full  = cnt_a_r >= size_a;
  assign a_we    = in_acc && !in_ch.to_second && !a_full;
  assign b_we    = in_acc && in_ch.to_second && a_full && (cnt_b_r < size_b);
  assign b_done  = in_acc && in_ch.to_second && a_full &&
                   (({1'b0, cnt_b_r} + 1'b1) >= {1'b0, size_b});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
    end else if (b_done) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
    end else begin
      if (a_we) cnt_a_r <= cnt_a_r + 1'b1;
      if (b_we) cnt_b_r <= cnt_b_r + 1'b1;
    end
  end

  // sequencing registers
  logic [CW-1:0]    sw_k_r, base_r, a_addr;
  logic [IDX_W-1:0] sw_row_r, sw_col_r, wr_row_r, wr_col_r;
  logic             rdv_r;
  logic [IDX_W-1:0] h_r, i_r, oc_r;
  logic [DRW-1:0]   dr_r;
  logic             inj_v_r, inj_first_r;
  logic [IDX_W-1:0] inj_h_r;
  elem_t            mem_a [0:DEPTH-1];
  elem_t            mem_b [0:DEPTH-1];
  elem_t            a_q_r, b_q_r;

  logic sw_issue, sw_col_end, row_issue, row_end, col_end, row_last, out_acc, snap;

  assign sw_issue   = (state_r == S_SWEEP) && (sw_k_r < size_b);
  assign sw_col_end = ({1'b0, sw_col_r} + 1'b1) == ncols;
  assign row_issue  = (state_r == S_ROW);
  assign row_end    = ({1'b0, h_r} + 1'b1) == ca_d;
  assign col_end    = ({1'b0, oc_r} + 1'b1) == ncols;
  assign row_last   = ({1'b0, i_r} + 1'b1) == r_d;
  assign out_acc    = out_ch.valid && out_ch.ready;
  assign snap       = (state_r == S_DRAIN) && (dr_r == DRW'(DRAIN_LEN));
  assign a_addr     = base_r + CW'(h_r);

  always_ff @(posedge clk) begin
    if (a_we) mem_a[cnt_a_r[AW-1:0]] <= in_elem;
    a_q_r <= mem_a[a_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[cnt_b_r[AW-1:0]] <= in_elem;
    b_q_r <= mem_b[sw_k_r[AW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:  if (b_done) state_nxt = S_SWEEP;
      S_SWEEP: if (!sw_issue) state_nxt = S_ROW;
      S_ROW:   if (row_end) state_nxt = S_DRAIN;
      S_DRAIN: if (snap) state_nxt = S_OUT;
      S_OUT: begin
        if (out_acc && col_end) state_nxt = row_last ? S_LOAD : S_ROW;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      rdv_r   <= 1'b0;
      inj_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= sw_issue;
      inj_v_r <= row_issue;
    end
    inj_first_r <= (h_r == '0);
    inj_h_r     <= h_r;
    wr_row_r    <= sw_row_r;
    wr_col_r    <= sw_col_r;

    if (state_r == S_LOAD) begin
      sw_k_r   <= '0;
      sw_row_r <= '0;
      sw_col_r <= '0;
      h_r      <= '0;
      i_r      <= '0;
      base_r   <= '0;
    end
    if (sw_issue) begin
      sw_k_r <= sw_k_r + 1'b1;
      if (sw_col_end) begin
        sw_col_r <= '0;
        sw_row_r <= sw_row_r + 1'b1;
      end else begin
        sw_col_r <= sw_col_r + 1'b1;
      end
    end
    if (row_issue) h_r <= h_r + 1'b1;
    if (state_r != S_DRAIN) dr_r <= '0;
    else dr_r <= dr_r + 1'b1;
    if (snap) oc_r <= '0;
    if (state_r == S_OUT && out_acc) begin
      if (col_end) begin
        oc_r   <= '0;
        h_r    <= '0;
        i_r    <= i_r + 1'b1;
        base_r <= base_r + CW'(ca_d);
      end else begin
        oc_r <= oc_r + 1'b1;
      end
    end
  end

  // cell row
  cell_ctl_t ctl;
  tok_t      tok_c [0:MAX_DIM];
  elem_t     res_c [0:MAX_DIM];

  assign ctl = '{mul: op_r, cplx: kind_r, brd_row: i_r, b_we: rdv_r, b_row: wr_row_r,
                 b_col: wr_col_r, snap: snap, shift: out_acc};
  assign tok_c[0] = '{v: inj_v_r, first: inj_first_r, h: inj_h_r, a: a_q_r};
  assign res_c[MAX_DIM] = '0;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    mae_cell #(.IDX(j)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .b_wdata (b_q_r),
      .tok_in  (tok_c[j]),
      .tok_out (tok_c[j+1]),
      .res_in  (res_c[j+1]),
      .res_out (res_c[j])
    );
  end

  assign out_ch.valid   = (state_r == S_OUT);
  assign out_ch.out_row = i_r;
  assign out_ch.out_col = oc_r;
  assign out_ch.res_re  = res_c[0].re;
  assign out_ch.res_im  = kind_r ? res_c[0].im : '0;
  assign out_ch.last    = row_last && col_end;

endmodule

[hdl/mae_checker.sv]
// Port-level checks for the engine, bound to the top level.
`timescale 1ns / 1ps
module mae_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [31:0] out_res_re,
  input logic [2:0]  out_col
);

  // no input is taken while results are pending
  a_no_load_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while results pending");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
    else $error("results continue after last");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last && out_col != 3'd7) |=>
    (!out_valid || out_col == $past(out_col) + 3'd1 || out_col == 3'd0))
    else $error("column order broken");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_res_re) && $stable(out_col)))
    else $error("stalled result changed");

endmodule

bind matrix_add_multiply_engine_top mae_checker u_mae_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_last   (out_ch.last),
  .out_res_re (out_ch.res_re),
  .out_col    (out_ch.out_col)
);

[tb/tb.sv]
// Self-checking testbench for the matrix add/multiply engine top level.
`timescale 1ns / 1ps
module tb;
  import mae_pkg::*;

  localparam int WD_LIMIT = 20000;
  localparam int SETTLE   = 100;
  localparam int RAND_ITEMS = 280;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] re;
    logic [31:0] im;
    logic        last;
  } res_t;

  typedef struct {
    bit        is_cfg;
    bit [3:0]  r, ca, cb;
    bit        op, kind;
    bit        ts;
    bit [31:0] re, im;
    bit        chk;
    bit [31:0] ere, eim;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic [3:0] cfg_data;

  mae_in_if  in_ch();
  mae_out_if out_ch();

  matrix_add_multiply_engine_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // predictor state
  logic [3:0]  m_rows, m_cols_a, m_cols_b;
  logic        m_mul, m_cplx;
  elem_t       m_sa [64];
  elem_t       m_sb [64];
  int          m_cnt_a, m_cnt_b;
  res_t        pending [$];
  res_t        last_pred;
  int          errors;
  bit          hold_req;
  int          items_sent;
  dir_row_t    dir_tab [$];

  function automatic int dim_of(logic [3:0] d);
    if (d == 0) return 1;
    if (d > 8) return 8;
    return int'(d);
  endfunction

  function automatic int size_a_now();
    return dim_of(m_rows) * dim_of(m_cols_a);
  endfunction

  task automatic predict_elem(bit ts, logic [31:0] re, logic [31:0] im);
    int r, ca, cb, oc, sb;
    logic [31:0] acc_re, acc_im;
    elem_t ea, eb;
    res_t o;
    r  = dim_of(m_rows);
    ca = dim_of(m_cols_a);
    cb = dim_of(m_cols_b);
    oc = m_mul ? cb : ca;
    sb = m_mul ? ca * cb : r * ca;
    if (!ts) begin
      if (m_cnt_a < r * ca) begin
        m_sa[m_cnt_a] = '{im: im, re: re};
        m_cnt_a++;
      end
    end else if (m_cnt_a >= r * ca) begin
      if (m_cnt_b < sb) begin
        m_sb[m_cnt_b] = '{im: im, re: re};
        m_cnt_b++;
      end
      if (m_cnt_b >= sb) begin
        for (int i = 0; i < r; i++) begin
          for (int j = 0; j < oc; j++) begin
            acc_re = '0;
            acc_im = '0;
            if (m_mul) begin
              for (int h = 0; h < ca; h++) begin
                ea = m_sa[i * ca + h];
                eb = m_sb[h * cb + j];
                if (m_cplx) begin
                  acc_re = acc_re + ea.re * eb.re - ea.im * eb.im;
                  acc_im = acc_im + ea.re * eb.im + ea.im * eb.re;
                end else begin
                  acc_re = acc_re + ea.re * eb.re;
                end
              end
            end else begin
              ea = m_sa[i * ca + j];
              eb = m_sb[i * ca + j];
              acc_re = ea.re + eb.re;
              acc_im = ea.im + eb.im;
            end
            if (!m_cplx) acc_im = '0;
            o.row  = i[2:0];
            o.col  = j[2:0];
            o.re   = acc_re;
            o.im   = acc_im;
            o.last = (i == r - 1) && (j == oc - 1);
            pending.push_back(o);
            last_pred = o;
          end
        end
        m_cnt_a = 0;
        m_cnt_b = 0;
      end
    end
  endtask

  // one request on the input channel; valid stays up across back-to-back requests
  task automatic send_elem(bit ts, logic [31:0] re, logic [31:0] im);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.to_second <= ts;
    in_ch.elem_re   <= re;
    in_ch.elem_im   <= im;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_elem(ts, re, im);
  endtask

  // results may still be in flight with nothing predicted, so settle afterwards too
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic [3:0] r, logic [3:0] ca, logic [3:0] cb,
                            logic op, logic kind);
    logic [3:0] vals [5];
    logic [2:0] idxs [5];
    vals = '{r, ca, cb, {3'b0, op}, {3'b0, kind}};
    idxs = '{REG_ROWS_A, REG_COLS_A, REG_COLS_B, REG_OPERATION, REG_ELEM_KIND};
    for (int i = 0; i < 5; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      case (idxs[i])
        REG_ROWS_A:    m_rows   = vals[i];
        REG_COLS_A:    m_cols_a = vals[i];
        REG_COLS_B:    m_cols_b = vals[i];
        REG_OPERATION: m_mul    = vals[i][0];
        REG_ELEM_KIND: m_cplx   = vals[i][0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [3:0] rand_dim();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 4'd0;
    if (p == 1) return 4'($urandom_range(9, 15));
    if (p == 2) return 4'($urandom_range(4, 8));
    return 4'($urandom_range(1, 3));
  endfunction

  // one full matrix job with random content, optional noise and an optional mid-load rewrite
  task automatic run_job(bit partial);
    int split, done_b;
    if ($urandom_range(0, 5) == 0 && m_cnt_a < size_a_now())
      send_elem(1'b1, $urandom, $urandom);
    split  = partial ? $urandom_range(0, 7) : -1;
    done_b = 0;
    do begin
      if (m_cnt_a < size_a_now()) begin
        send_elem(1'b0, $urandom, $urandom);
        if (m_cnt_a == size_a_now() && $urandom_range(0, 5) == 0)
          send_elem(1'b0, $urandom, $urandom);
      end else begin
        if (done_b == split) begin
          drain();
          write_regs(rand_dim(), rand_dim(), rand_dim(), 1'($urandom), 1'($urandom));
        end
        send_elem(1'b1, $urandom, $urandom);
        done_b++;
      end
      items_sent++;
    end while (m_cnt_a != 0 || m_cnt_b != 0 || pending.size() == 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int w;
    res_t e;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      w = hold_req ? 300 : $urandom_range(0, 5);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d re %h im %h", $time,
                 out_ch.out_row, out_ch.out_col, out_ch.res_re, out_ch.res_im);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_ch.out_row !== e.row || out_ch.out_col !== e.col ||
            out_ch.res_re !== e.re || out_ch.res_im !== e.im ||
            out_ch.last !== e.last) begin
          $display("%0t: mismatch exp r%0d c%0d %h %h l%0d act r%0d c%0d %h %h l%0d",
                   $time, e.row, e.col, e.re, e.im, e.last, out_ch.out_row,
                   out_ch.out_col, out_ch.res_re, out_ch.res_im, out_ch.last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request
  initial begin
    int idle;
    idle = 0;
    while (idle < WD_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_row_t d;
    errors = 0;
    hold_req = 1'b0;
    items_sent = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.to_second <= 1'b0;
    in_ch.elem_re <= '0;
    in_ch.elem_im <= '0;
    m_rows = 4'd1; m_cols_a = 4'd1; m_cols_b = 4'd1; m_mul = 1'b0; m_cplx = 1'b0;
    m_cnt_a = 0; m_cnt_b = 0;

    // after reset: 1x1 integer add
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1, 32'h5, 0, 0, 0, 0});  // B before A
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 0, 32'h1, 0, 0, 0, 0});  // A already full
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1, 32'h1, 0, 1, 32'h80000000, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 0, 32'h80000000, 0, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1, 32'h80000000, 0, 1, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 0, 32'hffffffff, 32'h7fffffff, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1, 32'hffffffff, 32'h80000000, 1,
                        32'hfffffffe, 0});
    dir_tab.push_back('{1, 1, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 0, 32'h1, 32'h7fffffff, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1, 32'h0, 32'h1, 1, 32'h1, 32'h80000000});
    // zero dimensions act as 1
    dir_tab.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 0, 32'h3, 32'hdead, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1, 32'h5, 32'hbeef, 1, 32'hf, 0});
    dir_tab.push_back('{1, 2, 2, 2, 1, 1, 0, 0, 0, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 0, 32'hffffffff, 32'h1, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 0, 32'h2, 32'hffffffff, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1, 32'h7fffffff, 32'h7fffffff, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1, 32'h80000000, 32'h3, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1, 32'hffff0000, 32'h80000000, 0, 0, 0});
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1, 32'h1, 32'hffffffff, 0, 0, 0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      d = dir_tab[k];
      if (d.is_cfg) begin
        drain();
        write_regs(d.r, d.ca, d.cb, d.op, d.kind);
      end else begin
        send_elem(d.ts, d.re, d.im);
        if (d.chk && (last_pred.re !== d.ere || last_pred.im !== d.eim ||
                      last_pred.last !== 1'b1)) begin
          $display("%0t: prediction exp %h %h act %h %h", $time, d.ere, d.eim,
                   last_pred.re, last_pred.im);
          errors++;
        end
      end
    end

    // largest job: 8x8 by 8x8 complex product under a long result hold-off
    drain();
    write_regs(4'd15, 4'd8, 4'd8, 1'b1, 1'b1);
    hold_req = 1'b1;
    run_job(1'b0);
    // next job offered at once, so its first request waits behind the held-off results
    run_job(1'b0);

    while (items_sent < RAND_ITEMS) begin
      drain();
      write_regs(rand_dim(), rand_dim(), rand_dim(), 1'($urandom), 1'($urandom));
      run_job($urandom_range(0, 5) == 0);
    end

    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
